/* rtl/binned_rms_envelope_macros.svh */
// Assertion macros for the checker file of the binned RMS envelope.
// No dependencies; include by bare file name.
`ifndef BINNED_RMS_ENVELOPE_MACROS_SVH
`define BINNED_RMS_ENVELOPE_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define BRE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("binned_rms_envelope: assertion failed");

// Next-cycle implication, disabled while rst is high
`define BRE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("binned_rms_envelope: assertion failed");

`endif

/* rtl/bre_pkg.sv */
// Shared widths, codes and helper functions of the binned RMS envelope.
// No dependencies; imported by every module of the block.
package bre_pkg;

   // Field and state widths
   localparam int SAMPLE_BITS   = 24;
   localparam int POSITION_BITS = 24;
   localparam int RANGE_BITS    = 24;
   localparam int COUNT_BITS    = 16;
   localparam int SUM_BITS      = 62;
   localparam int RMS_BITS      = 23;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 24;

   // Stream data widths, rounded up to whole bytes
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((RMS_BITS + 7) / 8) * 8;

   // Datapath widths
   localparam int PROD_BITS = 2 * SAMPLE_BITS;
   localparam int QUOT_BITS = 64;
   localparam int ROOT_BITS = QUOT_BITS / 2;
   localparam int ADD_BITS  = ((SUM_BITS > PROD_BITS) ? SUM_BITS : PROD_BITS) + 1;
   localparam int CMP_BITS  = ((POSITION_BITS > RANGE_BITS) ? POSITION_BITS : RANGE_BITS) + 1;

   // Step counter widths of the serial units
   localparam int SQR_CNT_BITS  = $clog2(SAMPLE_BITS);
   localparam int DIV_CNT_BITS  = $clog2(QUOT_BITS);
   localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS);

   // Alignment of the sum of squares to a Q0.46 mean before the root
   localparam int SCALE_UP = (SAMPLE_BITS <= 24) ? (48 - 2 * SAMPLE_BITS) : 0;
   localparam int SCALE_DN = (SAMPLE_BITS > 24) ? (2 * SAMPLE_BITS - 48) : 0;

   localparam logic [SUM_BITS-1:0]      SUM_MAX     = {SUM_BITS{1'b1}};
   localparam logic [POSITION_BITS-1:0] POS_MAX     = {POSITION_BITS{1'b1}};
   localparam logic [RMS_BITS-1:0]      RMS_MAX     = {RMS_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0]    SPB_DEFAULT = COUNT_BITS'(1024);

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_RANGE_START = 2'd0,
      CSR_RANGE_END   = 2'd1,
      CSR_BIN_LENGTH  = 2'd2
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_ROOT,
      ST_HOLD
   } state_type;

   // Align the sum of squares for the divider
   function automatic logic [QUOT_BITS-1:0] scale_sum(input logic [SUM_BITS-1:0] sum);
      logic [QUOT_BITS-1:0] wide;
      wide = QUOT_BITS'(sum);
      return (wide << SCALE_UP) >> SCALE_DN;
   endfunction

endpackage

/* rtl/bre_squarer.sv */
// Bit-serial squarer: one multiplier bit per cycle, shift-and-add.
// Depends on bre_pkg.
module bre_squarer import bre_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SAMPLE_BITS-1:0] mag,
   output logic                   done,
   output logic [PROD_BITS-1:0]   product
);

   logic [SAMPLE_BITS:0]      hi_ff, hi_in;
   logic [SAMPLE_BITS-1:0]    lo_ff, lo_in;
   logic [SAMPLE_BITS-1:0]    mcand_ff;
   logic [SQR_CNT_BITS-1:0]   cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic [SAMPLE_BITS:0]      partial;

   // Add the multiplicand on a set bit, then shift the pair right
   always_comb begin
      partial = hi_ff + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      hi_in   = {1'b0, partial[SAMPLE_BITS:1]};
      lo_in   = {partial[0], lo_ff[SAMPLE_BITS-1:1]};
   end

   // Step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         hi_ff    <= '0;
         lo_ff    <= mag;
         mcand_ff <= mag;
         cnt_ff   <= SQR_CNT_BITS'(SAMPLE_BITS - 1);
      end else if (busy_ff) begin
         hi_ff  <= hi_in;
         lo_ff  <= lo_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff[SAMPLE_BITS-1:0], lo_ff};

endmodule

/* rtl/bre_divider.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on bre_pkg.
module bre_divider import bre_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [QUOT_BITS-1:0]  dividend,
   input  logic [COUNT_BITS-1:0] divisor,
   output logic                  done,
   output logic [QUOT_BITS-1:0]  quotient
);

   logic [QUOT_BITS-1:0]  quo_ff;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] div_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [COUNT_BITS:0]   trial;
   logic [COUNT_BITS:0]   diff;
   logic                  ge;

   // Bring down the next dividend bit and try the subtract
   always_comb begin
      trial  = {rem_ff, quo_ff[QUOT_BITS-1]};
      diff   = trial - {1'b0, div_ff};
      ge     = trial >= {1'b0, div_ff};
      rem_in = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
   end

   // Step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath: quotient bits shift in where dividend bits leave
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
         cnt_ff <= DIV_CNT_BITS'(QUOT_BITS - 1);
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[QUOT_BITS-2:0], ge};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/bre_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on bre_pkg.
module bre_sqrt import bre_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [QUOT_BITS-1:0] radicand,
   output logic                 done,
   output logic [ROOT_BITS-1:0] root
);

   logic [QUOT_BITS-1:0]     rad_ff;
   logic [ROOT_BITS:0]       rem_ff, rem_in;
   logic [ROOT_BITS-1:0]     root_ff;
   logic [ROOT_CNT_BITS-1:0] cnt_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [ROOT_BITS+2:0]     trial_rem;
   logic [ROOT_BITS+2:0]     trial_sub;
   logic [ROOT_BITS+2:0]     diff;
   logic                     ge;

   // Bring down two radicand bits and try 4*root+1
   always_comb begin
      trial_rem = {rem_ff, rad_ff[QUOT_BITS-1:QUOT_BITS-2]};
      trial_sub = {1'b0, root_ff, 2'b01};
      diff      = trial_rem - trial_sub;
      ge        = trial_rem >= trial_sub;
      rem_in    = ge ? diff[ROOT_BITS:0] : trial_rem[ROOT_BITS:0];
   end

   // Step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= ROOT_CNT_BITS'(ROOT_BITS - 1);
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[QUOT_BITS-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= {root_ff[ROOT_BITS-2:0], ge};
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* rtl/binned_rms_envelope.sv */
// Binned RMS envelope: req_ carries signed samples (tdata) with tlast on the
// final sample of the data; rsp_ carries one RMS value per bin (tdata) with
// tlast on the last bin of the range; csr_ writes range_start (index 0),
// range_end (index 1) and the bin length (index 2); the user must write these
// only while the block is idle, which the block itself does not enforce.
// Samples are numbered from zero. From range_start the block sums squares
// over bins of the configured length and reports floor(sqrt(sum / bin length)),
// saturated to Q0.23. A sample marked tlast flushes the open bin; after it,
// or after the last bin, inputs are dropped until reset.
// Samples are taken only in the idle state: a sample outside any bin needs
// no further work, while a sample inside a bin is first squared by the
// bit-serial squarer. A sample that closes a bin then goes through the
// bit-serial divider and square root, and its result loads the output
// register once that is free; no new sample is taken until then.
// Reset clears position, sums, the finished flag and the output valid flag and
// loads the register defaults. When rsp_tready is low the result holds in the
// output register; the next bin's samples are still taken, and the block
// stalls only when a second result is ready before the first leaves.
module binned_rms_envelope import bre_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // Sample stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [23:0] sample
   input  logic                     req_tlast,
   // Result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [22:0] rms, [23] zero
   output logic                     rsp_tlast,
   // Register writes
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [RANGE_BITS-1:0]    range_start_ff;
   logic [RANGE_BITS-1:0]    range_end_ff;
   logic [COUNT_BITS-1:0]    spb_ff;

   logic [POSITION_BITS-1:0] pos_ff;
   logic [SUM_BITS-1:0]      sum_ff;
   logic [COUNT_BITS-1:0]    count_ff;
   logic [POSITION_BITS-1:0] open_pos_ff;
   logic                     finished_ff;
   logic                     last_ff;
   logic                     fin_ff;

   logic                     rsp_valid_ff;
   logic [RMS_BITS-1:0]      rsp_rms_ff;
   logic                     rsp_final_ff;

   logic                     accept;
   logic [SAMPLE_BITS-1:0]   sample_raw;
   logic [SAMPLE_BITS-1:0]   mag;
   logic [POSITION_BITS-1:0] open_pos_cur;
   logic                     bin_active;
   logic                     fin_in;
   logic [POSITION_BITS-1:0] pos_in;
   logic [ADD_BITS-1:0]      sum_wide;
   logic [SUM_BITS-1:0]      sum_next;
   logic [COUNT_BITS-1:0]    count_next;
   logic [COUNT_BITS-1:0]    bin_len;
   logic                     bin_close;
   logic                     rsp_free;
   logic [RMS_BITS-1:0]      rms_sat;

   logic                     sqr_start, sqr_done;
   logic [PROD_BITS-1:0]     sqr_product;
   logic                     div_start, div_done;
   logic [QUOT_BITS-1:0]     div_quotient;
   logic                     root_start, root_done;
   logic [ROOT_BITS-1:0]     root_value;
   logic                     rsp_load;

   // Take apart the input beat and precompute the per-sample decisions
   always_comb begin
      accept        = req_tvalid && req_tready;
      sample_raw    = req_tdata[SAMPLE_BITS-1:0];
      mag           = sample_raw[SAMPLE_BITS-1] ? (~sample_raw + 1'b1) : sample_raw;
      open_pos_cur  = (pos_ff == '0) ? POSITION_BITS'(range_start_ff) : open_pos_ff;
      bin_active    = (count_ff != '0) ||
                      ((pos_ff == open_pos_cur) &&
                       (CMP_BITS'(open_pos_cur) < CMP_BITS'(range_end_ff)));
      fin_in        = req_tlast || (pos_ff == POS_MAX) ||
                      ((CMP_BITS'(pos_ff) + CMP_BITS'(1)) >= CMP_BITS'(range_end_ff));
      pos_in        = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   end

   // Saturating accumulate and bin close test
   always_comb begin
      sum_wide   = ADD_BITS'(sum_ff) + ADD_BITS'(sqr_product);
      sum_next   = (sum_wide > ADD_BITS'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_BITS-1:0];
      count_next = count_ff + 1'b1;
      bin_len    = (spb_ff == '0) ? COUNT_BITS'(1) : spb_ff;
      bin_close  = (count_next >= bin_len) || last_ff;
      rsp_free   = !rsp_valid_ff || rsp_tready;
      rms_sat    = (root_value > ROOT_BITS'(RMS_MAX)) ? RMS_MAX : root_value[RMS_BITS-1:0];
   end

   // Sequencer: next state and unit starts
   always_comb begin
      state_in   = state_ff;
      sqr_start  = 1'b0;
      div_start  = 1'b0;
      root_start = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !finished_ff && bin_active) begin
               sqr_start = 1'b1;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (sqr_done) begin
               if (bin_close) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               root_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               if (rsp_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_start_ff <= '0;
         range_end_ff   <= '0;
         spb_ff         <= SPB_DEFAULT;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_RANGE_START: range_start_ff <= csr_wdata[RANGE_BITS-1:0];
            CSR_RANGE_END:   range_end_ff   <= csr_wdata[RANGE_BITS-1:0];
            CSR_BIN_LENGTH:  spb_ff         <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Bin state: advance position on each taken sample until finished, accumulate after squaring
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         open_pos_ff  <= '0;
         finished_ff  <= 1'b0;
         last_ff      <= 1'b0;
         fin_ff       <= 1'b0;
      end else begin
         if (accept && !finished_ff) begin
            pos_ff       <= pos_in;
            open_pos_ff  <= open_pos_cur;
            last_ff      <= req_tlast;
            fin_ff       <= fin_in;
            if (!bin_active && req_tlast) begin
               finished_ff <= 1'b1;
            end
         end
         if (state_ff == ST_SQUARE && sqr_done) begin
            if (bin_close) begin
               sum_ff   <= '0;
               count_ff <= '0;
               if (fin_ff) begin
                  finished_ff <= 1'b1;
               end else begin
                  open_pos_ff <= pos_ff;
               end
            end else begin
               sum_ff   <= sum_next;
               count_ff <= count_next;
            end
         end
      end
   end

   // Output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_rms_ff   <= rms_sat;
         rsp_final_ff <= fin_ff;
      end
   end

   bre_squarer u_squarer (
      .clock   (clock),
      .reset   (reset),
      .start   (sqr_start),
      .mag     (mag),
      .done    (sqr_done),
      .product (sqr_product)
   );

   bre_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scale_sum(sum_next)),
      .divisor  (bin_len),
      .done     (div_done),
      .quotient (div_quotient)
   );

   bre_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (div_quotient),
      .done     (root_done),
      .root     (root_value)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RMS_BITS){1'b0}}, rsp_rms_ff};
   assign rsp_tlast  = rsp_final_ff;

endmodule

/* rtl/bre_checker.sv */
// Port-level checks of the binned RMS envelope, bound to the top level.
// Depends on bre_pkg and binned_rms_envelope_macros.svh.
`include "binned_rms_envelope_macros.svh"

module bre_checker import bre_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tlast
);

   // Reset empties the output register
   `BRE_ASSERT_NXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_tvalid)

   // A stalled result beat holds
   `BRE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                   rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Padding above the rms field stays zero
   `BRE_ASSERT_IMP(a_rsp_pad, clock, reset, rsp_tvalid,
                   rsp_tdata[RSP_DATA_BITS-1:RMS_BITS] == '0)

   // Nothing follows the final bin until reset
   `BRE_ASSERT_NXT(a_none_after_final, clock, reset,
                   rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid)

endmodule

bind binned_rms_envelope bre_checker u_bre_checker (.*);
